### rtl/core/stable_softmax_normalizer_macros.svh
// Assertion macros for the softmax normalizer RTL.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef STABLE_SOFTMAX_NORMALIZER_MACROS_SVH
`define STABLE_SOFTMAX_NORMALIZER_MACROS_SVH
`ifndef SYNTHESIS
`define SSN_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("softmax normalizer assertion failed");
`define SSN_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("softmax normalizer assertion failed");
`else
`define SSN_ASSERT_NOW(lbl, ante, cons)
`define SSN_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

### rtl/core/ssn_pkg.sv
// Shared types, constants and the 2^-x table for the softmax normalizer.
// No dependencies.
package ssn_pkg;

  localparam int unsigned LW_W     = 16;
  localparam int unsigned WEIGHT_W = 17;
  localparam int unsigned POS_W    = 6;
  localparam int unsigned SUM_W    = 23;
  localparam int unsigned DIV_STEPS = 17;
  localparam logic [16:0] LOG2E_Q16 = 17'd94548;
  localparam logic [15:0] NEG_MOST  = 16'h8000;

  typedef enum logic [3:0] {
    S_LOAD,
    S_RD,
    S_EXP1,
    S_EXP2,
    S_EXP3,
    S_ERD,
    S_DINIT,
    S_DIV,
    S_OUT
  } ssn_state_e;

  typedef struct packed {
    logic load;
    logic mem_rd;
    logic exp_s1;
    logic exp_s2;
    logic exp_s3;
    logic e_rd;
    logic div_init;
    logic div_step;
    logic idx_clr;
    logic idx_inc;
    logic vec_clr;
  } ssn_cmd_t;

  typedef struct packed {
    logic last_idx;
  } ssn_status_t;

  // 2^(-j/16) in Q16
  function automatic logic [16:0] pow2_neg(input logic [4:0] j);
    logic [16:0] v;
    case (j)
      5'd0:    v = 17'd65536;
      5'd1:    v = 17'd62758;
      5'd2:    v = 17'd60097;
      5'd3:    v = 17'd57549;
      5'd4:    v = 17'd55109;
      5'd5:    v = 17'd52773;
      5'd6:    v = 17'd50535;
      5'd7:    v = 17'd48393;
      5'd8:    v = 17'd46341;
      5'd9:    v = 17'd44376;
      5'd10:   v = 17'd42495;
      5'd11:   v = 17'd40693;
      5'd12:   v = 17'd38968;
      5'd13:   v = 17'd37316;
      5'd14:   v = 17'd35734;
      5'd15:   v = 17'd34219;
      5'd16:   v = 17'd32768;
      default: v = 17'd32768;
    endcase
    return v;
  endfunction

endpackage

### rtl/core/stable_softmax_normalizer.sv
// Top level of the softmax normalizer: sequencer plus datapath.
// Depends on ssn_pkg, ssn_ctrl and ssn_dp.
//
//   channel | signals                                   | direction
//   in      | in_valid_i, in_stall_o, log_weight_i, last_i | word into block
//   out     | out_valid_o, out_stall_i, weight_o, position_o, last_res_o | word out
//
// Load accepts one word per cycle. After the word flagged last, the exp/sum pass
// handles each stored entry in turn: memory read, two multiplier stages, shift.
// Emit reads each exp value, runs the 17-step divider and holds the weight on stalls.
// No word is taken from the time last is accepted until the final weight leaves.
// Reset is asynchronous, active low; the entry store is not cleared.
module stable_softmax_normalizer #(
  parameter int unsigned MAX_ITEMS = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [15:0] log_weight_i,
  input  logic               last_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [16:0]        weight_o,
  output logic [5:0]         position_o,
  output logic               last_res_o
);
  import ssn_pkg::*;

  ssn_cmd_t    cmd;
  ssn_status_t status;

  // Sequencer
  ssn_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .last_i      (last_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Datapath
  ssn_dp #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .log_weight_i (log_weight_i),
    .weight_o     (weight_o),
    .position_o   (position_o)
  );

  assign last_res_o = status.last_idx;

endmodule

### rtl/core/ssn_ctrl.sv
// Sequencer for the softmax normalizer: load, exp/sum pass, divide/emit pass.
// Depends on ssn_pkg and the macros header.
`include "stable_softmax_normalizer_macros.svh"
module ssn_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 last_i,
  output logic                 in_stall_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  input  ssn_pkg::ssn_status_t status_i,
  output ssn_pkg::ssn_cmd_t    cmd_o
);
  import ssn_pkg::*;

  ssn_state_e state_q, state_d;
  logic [4:0] div_cnt_q, div_cnt_d;
  logic       in_acc;

  assign in_acc = in_valid_i && (state_q == S_LOAD);

  // State and divide step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_LOAD;
      div_cnt_q <= '0;
    end else begin
      state_q   <= state_d;
      div_cnt_q <= div_cnt_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d     = state_q;
    div_cnt_d   = div_cnt_q;
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    case (state_q)
      S_LOAD: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (last_i) begin
            cmd_o.idx_clr = 1'b1;
            state_d       = S_RD;
          end
        end
      end
      S_RD: begin
        cmd_o.mem_rd = 1'b1;
        state_d      = S_EXP1;
      end
      S_EXP1: begin
        cmd_o.exp_s1 = 1'b1;
        state_d      = S_EXP2;
      end
      S_EXP2: begin
        cmd_o.exp_s2 = 1'b1;
        state_d      = S_EXP3;
      end
      S_EXP3: begin
        cmd_o.exp_s3 = 1'b1;
        if (status_i.last_idx) begin
          cmd_o.idx_clr = 1'b1;
          state_d       = S_ERD;
        end else begin
          cmd_o.idx_inc = 1'b1;
          state_d       = S_RD;
        end
      end
      S_ERD: begin
        cmd_o.e_rd = 1'b1;
        state_d    = S_DINIT;
      end
      S_DINIT: begin
        cmd_o.div_init = 1'b1;
        div_cnt_d      = 5'(DIV_STEPS - 1);
        state_d        = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        div_cnt_d      = div_cnt_q - 5'd1;
        if (div_cnt_q == '0) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        out_valid_o = 1'b1;
        if (!out_stall_i) begin
          if (status_i.last_idx) begin
            cmd_o.vec_clr = 1'b1;
            state_d       = S_LOAD;
          end else begin
            cmd_o.idx_inc = 1'b1;
            state_d       = S_ERD;
          end
        end
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  `SSN_ASSERT_NEXT(a_last_starts_pass, in_acc && last_i, state_q == S_RD)
  `SSN_ASSERT_NEXT(a_div_ends_in_out, state_q == S_DIV && div_cnt_q == '0, out_valid_o)
  `SSN_ASSERT_NEXT(a_final_word_idles, out_valid_o && !out_stall_i && status_i.last_idx, !out_valid_o && !in_stall_o)
  `SSN_ASSERT_NOW(a_one_pass_cmd, 1'b1, $onehot0({cmd_o.load, cmd_o.mem_rd, cmd_o.exp_s1, cmd_o.exp_s2, cmd_o.exp_s3, cmd_o.e_rd, cmd_o.div_init, cmd_o.div_step}))

endmodule

### rtl/core/ssn_dp.sv
// Datapath for the softmax normalizer: entry store, max, exp unit, sum, divider.
// Depends on ssn_pkg.
module ssn_dp #(
  parameter int unsigned MAX_ITEMS = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ssn_pkg::ssn_cmd_t    cmd_i,
  output ssn_pkg::ssn_status_t status_o,
  input  logic signed [15:0]   log_weight_i,
  output logic [16:0]          weight_o,
  output logic [5:0]           position_o
);
  import ssn_pkg::*;

  localparam int unsigned AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int unsigned CW = $clog2(MAX_ITEMS + 1);

  logic [15:0]       entry_mem [MAX_ITEMS];
  logic [16:0]       e_mem     [MAX_ITEMS];
  logic [CW-1:0]     count_q;
  logic [AW-1:0]     idx_q;
  logic signed [15:0] max_q;
  logic [SUM_W-1:0]  sum_q;

  logic signed [15:0] x_q;
  logic [32:0]       y_q;
  logic [8:0]        k_q;
  logic [16:0]       hi_q;
  logic [23:0]       prod_q;
  logic [16:0]       e_rd_q;
  logic [22:0]       rem_q;
  logic [16:0]       low_q;
  logic [16:0]       quot_q;

  logic              store_en;
  logic [16:0]       dif;
  logic [15:0]       mag;
  logic [32:0]       y_d;
  logic [16:0]       hi, lo;
  logic [11:0]       dlt;
  logic [16:0]       val;
  logic [4:0]        k5;
  logic [17:0]       rnd_sum;
  logic [16:0]       e_val;
  logic [32:0]       num;
  logic [23:0]       trial;
  logic              ge;

  assign store_en = cmd_i.load && (count_q < CW'(MAX_ITEMS));
  assign status_o.last_idx = ((CW'(idx_q) + CW'(1)) == count_q);

  // Exp stage 1: distance from max times log2(e)
  assign dif = {max_q[15], max_q} - {x_q[15], x_q};
  assign mag = dif[15:0];
  assign y_d = 33'(mag) * 33'(LOG2E_Q16);

  // Exp stage 2: table lookup and interpolation product
  assign hi  = pow2_neg({1'b0, y_q[23:20]});
  assign lo  = pow2_neg({1'b0, y_q[23:20]} + 5'd1);
  assign dlt = 12'(hi - lo);

  // Exp stage 3: interpolate and apply integer shift with rounding
  assign val     = hi_q - 17'((prod_q + 24'd2048) >> 12);
  assign k5      = k_q[4:0];
  assign rnd_sum = {1'b0, val} + (18'd1 << (k5 - 5'd1));
  always_comb begin
    if (k_q == '0) begin
      e_val = val;
    end else if (k_q > 9'd16) begin
      e_val = '0;
    end else begin
      e_val = 17'(rnd_sum >> k5);
    end
  end

  // Divider: one quotient bit a step
  assign num   = {e_rd_q, 16'b0} + 33'(sum_q[SUM_W-1:1]);
  assign trial = {rem_q, low_q[16]};
  assign ge    = trial >= {1'b0, sum_q};

  // Store entries and exp values
  always_ff @(posedge clk_i) begin
    if (store_en) begin
      entry_mem[count_q[AW-1:0]] <= log_weight_i;
    end
    if (cmd_i.mem_rd) begin
      x_q <= entry_mem[idx_q];
    end
    if (cmd_i.exp_s3) begin
      e_mem[idx_q] <= e_val;
    end
    if (cmd_i.e_rd) begin
      e_rd_q <= e_mem[idx_q];
    end
  end

  // Exp pipeline and divider payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.exp_s1) begin
      y_q <= y_d;
    end
    if (cmd_i.exp_s2) begin
      k_q    <= y_q[32:24];
      hi_q   <= hi;
      prod_q <= 24'(dlt) * 24'(y_q[19:8]);
    end
    if (cmd_i.div_init) begin
      rem_q  <= 23'(num[32:17]);
      low_q  <= num[16:0];
      quot_q <= '0;
    end else if (cmd_i.div_step) begin
      rem_q  <= ge ? 23'(trial - {1'b0, sum_q}) : trial[22:0];
      low_q  <= {low_q[15:0], 1'b0};
      quot_q <= {quot_q[15:0], ge};
    end
  end

  // Vector state: count, max, sum, index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      max_q   <= NEG_MOST;
      sum_q   <= '0;
      idx_q   <= '0;
    end else begin
      if (cmd_i.vec_clr) begin
        count_q <= '0;
        max_q   <= NEG_MOST;
        sum_q   <= '0;
      end else begin
        if (store_en) begin
          count_q <= count_q + CW'(1);
          if (log_weight_i > max_q) begin
            max_q <= log_weight_i;
          end
        end
        if (cmd_i.idx_clr && cmd_i.load) begin
          sum_q <= '0;
        end else if (cmd_i.exp_s3) begin
          sum_q <= sum_q + SUM_W'(e_val);
        end
      end
      if (cmd_i.idx_clr) begin
        idx_q <= '0;
      end else if (cmd_i.idx_inc) begin
        idx_q <= idx_q + AW'(1);
      end
    end
  end

  assign weight_o   = quot_q;
  assign position_o = POS_W'(idx_q);

endmodule
